/* hw/rtl/sla_pkg.sv */
// Shared constants, codes and types of the lowest-free-first slot allocator.
package sla_pkg;

   localparam int SLOTS = 2048;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = IDX_W + 1;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_BAD_FREE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP_TOP,
      S_POP_RD,
      S_POP_CMP,
      S_PUSH_RD,
      S_PUSH_CMP,
      S_EMIT
   } state_type;

endpackage

/* hw/rtl/sla_channels.sv */
// Request and response channel interfaces of the slot allocator.
interface sla_req_if import sla_pkg::*; ();
   logic              valid;
   logic              ready;
   opcode_type        opcode;
   logic [IDX_W-1:0]  slot_index;

   modport source (output valid, output opcode, output slot_index, input ready);
   modport sink   (input valid, input opcode, input slot_index, output ready);
endinterface

interface sla_rsp_if import sla_pkg::*; ();
   logic              valid;
   logic              ready;
   status_type        status;
   logic [IDX_W-1:0]  granted_index;

   modport source (output valid, output status, output granted_index, input ready);
   modport sink   (input valid, input status, input granted_index, output ready);
endinterface

/* hw/rtl/slot_allocator_lowest_free_first_core.sv */
// Lowest-free-first slot allocator: bump pointer plus a min-heap free list in one RAM.
//
//   channel  | dir | handshake     | payload
//   req_ch   | in  | valid / ready | opcode, slot_index
//   rsp_ch   | out | valid / ready | status, granted_index
//   csr      | in  | csr_wr_en     | csr_wr_data (slot_count)
//
// Bump allocate, bump free and rejected requests go from S_IDLE straight to S_EMIT.
// Heap pop takes the root and the last entry in S_POP_TOP, then walks down in S_POP_RD / S_POP_CMP;
// heap push walks up from the new leaf in S_PUSH_RD / S_PUSH_CMP until the root or a parent no larger.
// At most 10 levels, one RAM read and one compare each.
// Reset is synchronous; the heap RAM needs no clearing, only entries below the fill are read.
// A response held by rsp_ch.ready does not block the next request beat.
module slot_allocator_lowest_free_first_core import sla_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   sla_req_if.sink           req_ch,
   sla_rsp_if.source         rsp_ch,
   input  logic              csr_wr_en,
   input  logic [CNT_W-1:0]  csr_wr_data
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  heap_fill_ff, heap_fill_in;
   logic [CNT_W-1:0]  bump_ff, bump_in;
   logic [CNT_W-1:0]  slot_count_ff, slot_count_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [IDX_W-1:0]  val_ff, val_in;
   status_type        res_status_ff, res_status_in;
   logic [IDX_W-1:0]  res_grant_ff, res_grant_in;
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [IDX_W-1:0]  rsp_grant_ff;

   logic [IDX_W-1:0]  heap_mem [SLOTS];
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr, mem_wdata;
   logic [IDX_W-1:0]  rd_a_addr, rd_b_addr;
   logic [IDX_W-1:0]  rd_a_ff, rd_b_ff;

   logic              req_fire, rsp_free, rsp_load;
   logic [CNT_W-1:0]  bound, idx_ext, left_pos, right_pos;
   logic [IDX_W-1:0]  parent_pos, child_val, child_pos;
   logic              take_pop, take_push, pick_right;
   logic              pop_stop, pop_descend, push_root, push_up;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_load = (state_ff == S_EMIT) && rsp_free;

   assign bound = (slot_count_ff > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : slot_count_ff;
   assign idx_ext = {1'b0, req_ch.slot_index};

   assign take_pop  = (req_ch.opcode == OP_ALLOC) && (heap_fill_ff != '0);
   assign take_push = (req_ch.opcode == OP_FREE) && (idx_ext < bump_ff)
                      && ((idx_ext + CNT_W'(1)) != bump_ff)
                      && (heap_fill_ff < CNT_W'(SLOTS));

   assign parent_pos = (pos_ff - IDX_W'(1)) >> 1;
   assign left_pos   = {pos_ff, 1'b1};
   assign right_pos  = left_pos + CNT_W'(1);
   assign pick_right = (right_pos < heap_fill_ff) && (rd_b_ff < rd_a_ff);
   assign child_val  = pick_right ? rd_b_ff : rd_a_ff;
   assign child_pos  = pick_right ? right_pos[IDX_W-1:0] : left_pos[IDX_W-1:0];

   assign pop_stop    = left_pos >= heap_fill_ff;
   assign pop_descend = child_val < val_ff;
   assign push_root   = pos_ff == '0;
   assign push_up     = val_ff < rd_a_ff;

   assign slot_count_in = csr_wr_en ? csr_wr_data : slot_count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (take_pop) state_in = S_POP_TOP;
               else if (take_push) state_in = S_PUSH_RD;
               else state_in = S_EMIT;
            end
         end
         S_POP_TOP:  state_in = S_POP_RD;
         S_POP_RD:   state_in = pop_stop ? S_EMIT : S_POP_CMP;
         S_POP_CMP:  state_in = pop_descend ? S_POP_RD : S_EMIT;
         S_PUSH_RD:  state_in = push_root ? S_EMIT : S_PUSH_CMP;
         S_PUSH_CMP: state_in = push_up ? S_PUSH_RD : S_EMIT;
         S_EMIT: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      heap_fill_in  = heap_fill_ff;
      bump_in       = bump_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      res_status_in = res_status_ff;
      res_grant_in  = res_grant_ff;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff;
      mem_wdata     = val_ff;
      rd_a_addr     = '0;
      rd_b_addr     = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_status_in = ST_OK;
               res_grant_in  = '0;
               if (req_ch.opcode == OP_ALLOC) begin
                  if (take_pop) begin
                     rd_b_addr    = IDX_W'(heap_fill_ff - CNT_W'(1));
                     heap_fill_in = heap_fill_ff - CNT_W'(1);
                     pos_in       = '0;
                  end else if (bump_ff < bound) begin
                     res_grant_in = bump_ff[IDX_W-1:0];
                     bump_in      = bump_ff + CNT_W'(1);
                  end else begin
                     res_status_in = ST_FULL;
                  end
               end else begin
                  if (idx_ext >= bump_ff) begin
                     res_status_in = ST_BAD_FREE;
                  end else if ((idx_ext + CNT_W'(1)) == bump_ff) begin
                     bump_in = bump_ff - CNT_W'(1);
                  end else if (heap_fill_ff >= CNT_W'(SLOTS)) begin
                     res_status_in = ST_BAD_FREE;
                  end else begin
                     pos_in       = heap_fill_ff[IDX_W-1:0];
                     val_in       = req_ch.slot_index;
                     heap_fill_in = heap_fill_ff + CNT_W'(1);
                  end
               end
            end
         end
         S_POP_TOP: begin
            res_grant_in = rd_a_ff;
            val_in       = rd_b_ff;
         end
         S_POP_RD: begin
            if (pop_stop) begin
               mem_we = 1'b1;
            end else begin
               rd_a_addr = left_pos[IDX_W-1:0];
               rd_b_addr = right_pos[IDX_W-1:0];
            end
         end
         S_POP_CMP: begin
            mem_we = 1'b1;
            if (pop_descend) begin
               mem_wdata = child_val;
               pos_in    = child_pos;
            end
         end
         S_PUSH_RD: begin
            if (push_root) mem_we = 1'b1;
            else rd_a_addr = parent_pos;
         end
         S_PUSH_CMP: begin
            mem_we = 1'b1;
            if (push_up) begin
               mem_wdata = rd_a_ff;
               pos_in    = parent_pos;
            end
         end
         S_EMIT: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) heap_mem[mem_waddr] <= mem_wdata;
      rd_a_ff <= heap_mem[rd_a_addr];
      rd_b_ff <= heap_mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         heap_fill_ff  <= '0;
         bump_ff       <= '0;
         slot_count_ff <= CNT_W'(SLOTS);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         heap_fill_ff  <= heap_fill_in;
         bump_ff       <= bump_in;
         slot_count_ff <= slot_count_in;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      res_status_ff <= res_status_in;
      res_grant_ff  <= res_grant_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_grant_ff  <= res_grant_ff;
      end
   end

   assign req_ch.ready         = state_ff == S_IDLE;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.granted_index = rsp_grant_ff;

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      heap_fill_ff <= CNT_W'(SLOTS))
      else $error("heap fill beyond capacity");

   a_bump_bound: assert property (@(posedge clock) disable iff (reset)
      bump_ff <= CNT_W'(SLOTS))
      else $error("bump pointer beyond capacity");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != S_IDLE)
      else $error("request beat did not start work");

   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff != S_IDLE) && (state_ff != S_EMIT))
      else $error("heap write outside an operation");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("finished result not presented");
`endif

endmodule
